@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/bep_pkg.sv @@
// ---------------------------------------------------------------------------
// bep_pkg
// Types, widths and the box edge table for the box edge projection block.
// ---------------------------------------------------------------------------
package bep_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int FIELD_W     = 32;
    localparam int CRD_W       = FIELD_W + 1;       // exact corner sum
    localparam int COEF_W      = 16;
    localparam int PROD_W      = COEF_W + CRD_W;
    localparam int CLIP_W      = 52;                // clip sum, signed
    localparam int QUO_W       = 32;                // quotient incl. overflow bit
    localparam int REM_W       = CLIP_W + QUO_W;
    localparam int NUM_POINTS  = 24;
    localparam int PT_IDX_W    = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int OUT_DEPTH   = 2;
    localparam int REG_W       = 64;
    localparam int ADDR_W      = 5;

    // register index, taken from paddr[4:3]
    typedef enum logic [1:0] {
        REG_DRAW_EDGES,
        REG_ROW_X,
        REG_ROW_Y,
        REG_ROW_W
    } t_reg_idx;

    typedef struct packed {
        logic signed [FIELD_W-1:0] origin_x;
        logic signed [FIELD_W-1:0] origin_y;
        logic signed [FIELD_W-1:0] origin_z;
        logic signed [FIELD_W-1:0] extent_x;
        logic signed [FIELD_W-1:0] extent_y;
        logic signed [FIELD_W-1:0] extent_z;
    } t_box;

    typedef struct packed {
        logic signed [FIELD_W-1:0] ndc_x;
        logic signed [FIELD_W-1:0] ndc_y;
        logic [3:0]                edge_number;
        logic                      end_point;
        logic                      last;
    } t_point;

    typedef struct packed {
        logic [3:0] edge_number;
        logic       end_point;
        logic       last;
    } t_tag;

    typedef struct packed {
        logic signed [CRD_W-1:0] px;
        logic signed [CRD_W-1:0] py;
        logic signed [CRD_W-1:0] pz;
        t_tag                    tag;
    } t_corner_word;

    typedef struct packed {
        logic [REG_W-1:0] row_x;
        logic [REG_W-1:0] row_y;
        logic [REG_W-1:0] row_w;
    } t_matrix;

    typedef struct packed {
        logic [CLIP_W-1:0] an_x;
        logic [CLIP_W-1:0] an_y;
        logic [CLIP_W-1:0] ad;
        logic              neg_x;
        logic              neg_y;
        logic              w_zero;
        t_tag              tag;
    } t_div_word;

    // corner at one end of an edge: bottom ring, top ring, then uprights
    function automatic logic [2:0] corner_of(logic [3:0] edge_idx, logic second);
        logic [5:0] ends;
        case (edge_idx)
            4'd0:    ends = {3'd0, 3'd1};
            4'd1:    ends = {3'd1, 3'd3};
            4'd2:    ends = {3'd3, 3'd2};
            4'd3:    ends = {3'd2, 3'd0};
            4'd4:    ends = {3'd4, 3'd5};
            4'd5:    ends = {3'd5, 3'd7};
            4'd6:    ends = {3'd7, 3'd6};
            4'd7:    ends = {3'd6, 3'd4};
            4'd8:    ends = {3'd0, 3'd4};
            4'd9:    ends = {3'd1, 3'd5};
            4'd10:   ends = {3'd3, 3'd7};
            4'd11:   ends = {3'd2, 3'd6};
            default: ends = 6'd0;
        endcase
        return second ? ends[2:0] : ends[5:3];
    endfunction

endpackage

@@ rtl/box_edge_projection_top.sv @@
// ---------------------------------------------------------------------------
// box_edge_projection_top
// Projects a box's edges, twelve in all, through a view-projection matrix.
// ---------------------------------------------------------------------------
// Each accepted box yields 24 words, both endpoints of every edge in fixed
// order, each divided by clip w and saturated to Q16.16; with draw_edges at 0
// a box is accepted and yields nothing. The corner walker emits one point
// per cycle while the corner queue has room, and boxes follow back to back.
// On its way to the result ports a word passes the corner queue write, three
// transform stages, a divider load stage, 32 divider stages, a result stage
// and the output queue. The math pipeline stalls as a whole only when the
// two-word output queue is full. Registers draw_edges, row x, row y and row w
// sit at byte addresses 0, 8, 16 and 24; the user must write them only while
// the block is idle, as the block itself does not enforce it.
module box_edge_projection_top import bep_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  t_box              i_box,
    output logic              empty,
    input  logic              pop,
    output t_point            o_point,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]  pwdata,
    output logic [REG_W-1:0]  prdata,
    output logic              pready
);

`include "assert_macros.svh"

    logic         r_draw_edges;
    t_matrix      r_matrix;
    t_reg_idx     w_idx;

    logic         w_q_push;
    logic         w_q_full;
    logic         w_q_pop;
    logic         w_q_empty;
    t_corner_word w_fr_word;
    t_corner_word w_q_word;
    logic         w_tr_valid;
    t_div_word    w_tr_word;
    logic         w_dv_valid;
    t_point       w_dv_point;
    logic         w_en;
    logic         w_out_push;
    logic         w_out_pop;

    t_point       r_buf [OUT_DEPTH];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_out_cnt;

    // configuration registers
    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_edges   <= 1'b1;
            r_matrix.row_x <= REG_W'(64'h0000_0000_0000_1000);
            r_matrix.row_y <= REG_W'(64'h0000_0000_1000_0000);
            r_matrix.row_w <= REG_W'(64'h1000_0000_0000_0000);
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_DRAW_EDGES: r_draw_edges   <= pwdata[0];
                REG_ROW_X:      r_matrix.row_x <= pwdata;
                REG_ROW_Y:      r_matrix.row_y <= pwdata;
                REG_ROW_W:      r_matrix.row_w <= pwdata;
                default:        r_draw_edges   <= r_draw_edges;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DRAW_EDGES: prdata = REG_W'(r_draw_edges);
            REG_ROW_X:      prdata = r_matrix.row_x;
            REG_ROW_Y:      prdata = r_matrix.row_y;
            REG_ROW_W:      prdata = r_matrix.row_w;
            default:        prdata = '0;
        endcase
    end

    // front: box intake and corner walk
    bep_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_box        (i_box),
        .i_draw_edges (r_draw_edges),
        .i_q_full     (w_q_full),
        .o_q_push     (w_q_push),
        .o_q_word     (w_fr_word)
    );

    bep_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_word  (w_fr_word),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_word  (w_q_word),
        .o_empty (w_q_empty)
    );

    // back: math pipeline advances while the output queue has room
    assign w_en = (r_out_cnt != 2'(OUT_DEPTH));

    bep_transform u_transform (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_q_empty (w_q_empty),
        .i_q_word  (w_q_word),
        .o_q_pop   (w_q_pop),
        .i_matrix  (r_matrix),
        .o_valid   (w_tr_valid),
        .o_word    (w_tr_word)
    );

    bep_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_tr_valid),
        .i_word  (w_tr_word),
        .o_valid (w_dv_valid),
        .o_point (w_dv_point)
    );

    // two-word output queue
    assign w_out_push = w_en && w_dv_valid;
    assign w_out_pop  = pop && !empty;
    assign empty      = (r_out_cnt == 2'd0);
    assign o_point    = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr      <= 1'b0;
            r_rd      <= 1'b0;
            r_out_cnt <= 2'd0;
        end else begin
            if (w_out_push) begin
                r_wr <= !r_wr;
            end
            if (w_out_pop) begin
                r_rd <= !r_rd;
            end
            r_out_cnt <= r_out_cnt + 2'(w_out_push) - 2'(w_out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_push) begin
            r_buf[r_wr] <= w_dv_point;
        end
    end

    `ASSERT_IMPL(a_out_cnt_bound, i_clk, i_rst_n, 1'b1, r_out_cnt <= 2'(OUT_DEPTH))
    `ASSERT_IMPL(a_last_is_final, i_clk, i_rst_n, !empty && o_point.last, o_point.edge_number == 4'd11 && o_point.end_point)
    `ASSERT_NEXT(a_drain_to_empty, i_clk, i_rst_n, w_out_pop && !w_out_push && r_out_cnt == 2'd1, empty)

endmodule

@@ rtl/bep_front.sv @@
// ---------------------------------------------------------------------------
// bep_front
// Accepts boxes; if draw_edges is set, walks 24 endpoints to the corner queue.
// ---------------------------------------------------------------------------
module bep_front import bep_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    output logic         o_full,
    input  t_box         i_box,
    input  logic         i_draw_edges,
    input  logic         i_q_full,
    output logic         o_q_push,
    output t_corner_word o_q_word
);

    logic                r_busy;
    logic [PT_IDX_W-1:0] r_idx;
    t_box                r_box;

    logic                w_emit;
    logic                w_done;
    logic                w_accept;
    logic [2:0]          w_corner;

    // walker handshake: next box may enter as the last point leaves
    assign w_emit   = r_busy && !i_q_full;
    assign w_done   = w_emit && (r_idx == PT_IDX_W'(NUM_POINTS - 1));
    assign o_full   = r_busy && !w_done;
    assign w_accept = i_push && !o_full;
    assign o_q_push = w_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (w_accept) begin
            r_busy <= i_draw_edges;
            r_idx  <= '0;
        end else if (w_emit) begin
            r_idx <= r_idx + 1'b1;
            if (w_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_box <= i_box;
        end
    end

    // corner coordinates, exact at 33 bits
    always_comb begin
        w_corner = corner_of(r_idx[PT_IDX_W-1:1], r_idx[0]);
        o_q_word.px = CRD_W'(r_box.origin_x)
                    + (w_corner[0] ? CRD_W'(r_box.extent_x) : CRD_W'(0));
        o_q_word.py = CRD_W'(r_box.origin_y)
                    + (w_corner[1] ? CRD_W'(r_box.extent_y) : CRD_W'(0));
        o_q_word.pz = CRD_W'(r_box.origin_z)
                    + (w_corner[2] ? CRD_W'(r_box.extent_z) : CRD_W'(0));
        o_q_word.tag.edge_number = r_idx[PT_IDX_W-1:1];
        o_q_word.tag.end_point   = r_idx[0];
        o_q_word.tag.last        = (r_idx == PT_IDX_W'(NUM_POINTS - 1));
    end

endmodule

@@ rtl/bep_queue.sv @@
// ---------------------------------------------------------------------------
// bep_queue
// Short corner queue between the walker and the math pipeline.
// ---------------------------------------------------------------------------
module bep_queue import bep_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_corner_word i_word,
    output logic         o_full,
    input  logic         i_pop,
    output t_corner_word o_word,
    output logic         o_empty
);

    t_corner_word           r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr;
    logic [QUEUE_PTR_W-1:0] r_rd;
    logic [QUEUE_PTR_W:0]   r_cnt;

    logic w_wr;
    logic w_rd;

    assign o_full  = (r_cnt == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_word  = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QUEUE_PTR_W+1)'(w_wr) - (QUEUE_PTR_W+1)'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_word;
        end
    end

endmodule

@@ rtl/bep_transform.sv @@
// ---------------------------------------------------------------------------
// bep_transform
// Matrix rows x, y, w applied to a corner; magnitudes and signs for divide.
// ---------------------------------------------------------------------------
module bep_transform import bep_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_q_empty,
    input  t_corner_word i_q_word,
    output logic         o_q_pop,
    input  t_matrix      i_matrix,
    output logic         o_valid,
    output t_div_word    o_word
);

    logic signed [PROD_W-1:0] r_prod [3][3];
    logic signed [CLIP_W-1:0] r_clip [3];
    t_tag                     r_tag1;
    t_tag                     r_tag2;
    logic                     r_v1;
    logic                     r_v2;
    logic                     r_v3;
    t_div_word                r_word;

    logic [REG_W-1:0]         w_row [3];
    logic signed [CRD_W-1:0]  w_p   [3];

    assign o_q_pop = i_en && !i_q_empty;
    assign w_row[0] = i_matrix.row_x;
    assign w_row[1] = i_matrix.row_y;
    assign w_row[2] = i_matrix.row_w;
    assign w_p[0]   = i_q_word.px;
    assign w_p[1]   = i_q_word.py;
    assign w_p[2]   = i_q_word.pz;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= !i_q_empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // products, clip sums, then sign split
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[r][k] <= $signed(w_row[r][COEF_W*k +: COEF_W]) * w_p[k];
                end
                r_clip[r] <= CLIP_W'(r_prod[r][0]) + CLIP_W'(r_prod[r][1])
                           + CLIP_W'(r_prod[r][2])
                           + (CLIP_W'($signed(w_row[r][COEF_W*3 +: COEF_W])) <<< FRAC_BITS);
            end
            r_tag1 <= i_q_word.tag;
            r_tag2 <= r_tag1;
            r_word.an_x   <= r_clip[0][CLIP_W-1] ? CLIP_W'(-r_clip[0]) : CLIP_W'(r_clip[0]);
            r_word.an_y   <= r_clip[1][CLIP_W-1] ? CLIP_W'(-r_clip[1]) : CLIP_W'(r_clip[1]);
            r_word.ad     <= r_clip[2][CLIP_W-1] ? CLIP_W'(-r_clip[2]) : CLIP_W'(r_clip[2]);
            r_word.neg_x  <= r_clip[0][CLIP_W-1] ^ r_clip[2][CLIP_W-1];
            r_word.neg_y  <= r_clip[1][CLIP_W-1] ^ r_clip[2][CLIP_W-1];
            r_word.w_zero <= (r_clip[2] == '0);
            r_word.tag    <= r_tag2;
        end
    end

    assign o_valid = r_v3;
    assign o_word  = r_word;

endmodule

@@ rtl/bep_divider.sv @@
// ---------------------------------------------------------------------------
// bep_divider
// Two-lane pipelined restoring divider, one quotient bit per stage, saturating.
// ---------------------------------------------------------------------------
module bep_divider import bep_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_div_word i_word,
    output logic      o_valid,
    output t_point    o_point
);

    logic              r_v   [QUO_W+1];
    logic [REM_W-1:0]  r_rx  [QUO_W+1];
    logic [REM_W-1:0]  r_ry  [QUO_W+1];
    logic [QUO_W-1:0]  r_qx  [QUO_W+1];
    logic [QUO_W-1:0]  r_qy  [QUO_W+1];
    t_div_word         r_dw  [QUO_W+1];
    logic              r_ov;
    t_point            r_out;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QUO_W; s++) begin
                r_v[s] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 0; s < QUO_W; s++) begin
                r_v[s+1] <= r_v[s];
            end
            r_ov <= r_v[QUO_W];
        end
    end

    // load: numerator scaled by the fraction bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx[0] <= REM_W'(i_word.an_x) << FRAC_BITS;
            r_ry[0] <= REM_W'(i_word.an_y) << FRAC_BITS;
            r_qx[0] <= '0;
            r_qy[0] <= '0;
            r_dw[0] <= i_word;
        end
    end

    // quotient bit QUO_W-1-s per stage; the top bit flags overflow
    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        logic [REM_W-1:0] w_dsh;
        assign w_dsh = REM_W'(r_dw[s].ad) << (QUO_W - 1 - s);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dw[s+1] <= r_dw[s];
                r_rx[s+1] <= (r_rx[s] >= w_dsh) ? r_rx[s] - w_dsh : r_rx[s];
                r_ry[s+1] <= (r_ry[s] >= w_dsh) ? r_ry[s] - w_dsh : r_ry[s];
                r_qx[s+1] <= r_qx[s] | (QUO_W'(r_rx[s] >= w_dsh) << (QUO_W - 1 - s));
                r_qy[s+1] <= r_qy[s] | (QUO_W'(r_ry[s] >= w_dsh) << (QUO_W - 1 - s));
            end
        end
    end

    // sign, saturation and zero-w handling
    function automatic logic [FIELD_W-1:0] fx_result(logic [QUO_W-1:0] q, logic neg,
                                                     logic wz);
        logic [FIELD_W-1:0] mag;
        mag = FIELD_W'(q[QUO_W-2:0]);
        if (wz) begin
            return '0;
        end else if (q[QUO_W-1]) begin
            return neg ? {1'b1, {(FIELD_W-1){1'b0}}} : {1'b0, {(FIELD_W-1){1'b1}}};
        end else begin
            return neg ? FIELD_W'(-mag) : mag;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.ndc_x       <= fx_result(r_qx[QUO_W], r_dw[QUO_W].neg_x, r_dw[QUO_W].w_zero);
            r_out.ndc_y       <= fx_result(r_qy[QUO_W], r_dw[QUO_W].neg_y, r_dw[QUO_W].w_zero);
            r_out.edge_number <= r_dw[QUO_W].tag.edge_number;
            r_out.end_point   <= r_dw[QUO_W].tag.end_point;
            r_out.last        <= r_dw[QUO_W].tag.last;
        end
    end

    assign o_valid = r_ov;
    assign o_point = r_out;

endmodule

@@ tb/box_edge_projection_checker.sv @@
// ---------------------------------------------------------------------------
// box_edge_projection_checker
// Watches the box and point channels and the register port, computes the
// expected points of each accepted box and compares every popped word.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module box_edge_projection_checker import bep_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    input  logic              full,
    input  t_box              i_box,
    input  logic              empty,
    input  logic              pop,
    input  t_point            o_point,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]  pwdata,
    input  logic              pready,
    output int                o_errors,
    output int                o_pending
);

    // shadow of the block's registers
    logic             edges_on;
    logic [REG_W-1:0] row_x, row_y, row_w;

    t_point points_due[$];
    int     errors;

    assign o_errors  = errors;

    // corner pairs, one per box edge, twelve in all
    localparam logic [2:0] EDGE_A [12] = '{0, 1, 3, 2, 4, 5, 7, 6, 0, 1, 3, 2};
    localparam logic [2:0] EDGE_B [12] = '{1, 3, 2, 0, 5, 7, 6, 4, 4, 5, 7, 6};

    function automatic longint signed coef_of(logic [REG_W-1:0] row, int k);
        logic signed [15:0] c;
        c = row[16*k +: 16];
        return longint'(c);
    endfunction

    function automatic longint signed clip_of(logic [REG_W-1:0] row,
                                              longint signed px, longint signed py,
                                              longint signed pz);
        return coef_of(row, 0) * px + coef_of(row, 1) * py + coef_of(row, 2) * pz
             + (coef_of(row, 3) <<< FRAC_BITS);
    endfunction

    // truncating fixed-point divide, saturated to 32 bits
    function automatic logic [31:0] ndc_div(longint signed num, longint signed den);
        logic            neg;
        logic [63:0]     an, ad, qi, r, q;
        neg = (num < 0) != (den < 0);
        an  = num < 0 ? -num : num;
        ad  = den < 0 ? -den : den;
        qi  = an / ad;
        r   = an % ad;
        if (qi >= (64'd1 << (31 - FRAC_BITS)))
            return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        q = qi;
        for (int i = 0; i < FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= ad) begin
                r = r - ad;
                q[0] = 1'b1;
            end
        end
        return neg ? 32'(-q) : q[31:0];
    endfunction

    task automatic project_box(t_box b);
        longint signed org [3];
        longint signed ext [3];
        longint signed p [3];
        longint signed cx, cy, cw;
        logic [2:0]    c;
        t_point        pt;
        int            n;
        org = '{longint'(b.origin_x), longint'(b.origin_y), longint'(b.origin_z)};
        ext = '{longint'(b.extent_x), longint'(b.extent_y), longint'(b.extent_z)};
        n = 0;
        for (int e = 0; e < 12; e++) begin
            for (int s = 0; s < 2; s++) begin
                c = s ? EDGE_B[e] : EDGE_A[e];
                for (int a = 0; a < 3; a++)
                    p[a] = org[a] + (c[a] ? ext[a] : 0);
                cx = clip_of(row_x, p[0], p[1], p[2]);
                cy = clip_of(row_y, p[0], p[1], p[2]);
                cw = clip_of(row_w, p[0], p[1], p[2]);
                pt.ndc_x       = cw == 0 ? '0 : ndc_div(cx, cw);
                pt.ndc_y       = cw == 0 ? '0 : ndc_div(cy, cw);
                pt.edge_number = 4'(e);
                pt.end_point   = 1'(s);
                pt.last        = n == 23;
                points_due     = {points_due, pt};
                n++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_point want;
        if (!i_rst_n) begin
            edges_on <= 1'b1;
            row_x    <= 64'h1000;
            row_y    <= 64'h1000_0000;
            row_w    <= 64'h1000_0000_0000_0000;
            errors   = 0;
            points_due.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[4:3]))
                    REG_DRAW_EDGES: edges_on <= pwdata[0];
                    REG_ROW_X:      row_x    <= pwdata;
                    REG_ROW_Y:      row_y    <= pwdata;
                    REG_ROW_W:      row_w    <= pwdata;
                    default:        edges_on <= edges_on;
                endcase
            end
            // accepted box
            if (push && !full && edges_on)
                project_box(i_box);
            // accepted point
            if (pop && !empty) begin
                if (points_due.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word %h", o_point);
                end else begin
                    want = points_due.pop_front();
                    if (want !== o_point) begin
                        errors++;
                        if (errors <= 10)
                            $display("word mismatch: expected x=%h y=%h e=%0d s=%0d l=%0d, got x=%h y=%h e=%0d s=%0d l=%0d",
                                want.ndc_x, want.ndc_y, want.edge_number,
                                want.end_point, want.last, o_point.ndc_x,
                                o_point.ndc_y, o_point.edge_number,
                                o_point.end_point, o_point.last);
                    end
                end
            end
        end
        o_pending <= points_due.size();
    end

endmodule

@@ tb/box_edge_projection_top_test.sv @@
// ---------------------------------------------------------------------------
// box_edge_projection_top_test
// Drives boxes and register writes into the projection block; a checker
// beside it predicts every edge point and counts the mismatches.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module box_edge_projection_top_test;
    import bep_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    logic              full;
    t_box              i_box;
    logic              empty;
    logic              pop;
    t_point            o_point;
    logic              psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [REG_W-1:0]  pwdata;
    logic [REG_W-1:0]  prdata;
    logic              pready;
    int                errors;
    int                pending;
    int                cycles;
    bit                calm;     // no idling in the last part

    box_edge_projection_top DUT (.*);

    box_edge_projection_checker checker_i (
        .i_clk, .i_rst_n, .push, .full, .i_box, .empty, .pop, .o_point,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver with random stall bursts
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (calm || stall == 0) begin
                pop <= 1'b1;
                if (!calm && $urandom_range(0, 15) == 0)
                    stall = $urandom_range(1, 19);
            end else begin
                pop <= 1'b0;
                stall--;
            end
        end
    end

    task automatic reg_write(t_reg_idx idx, logic [REG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 3;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic send_box(t_box b);
        int gap;
        if (!calm && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 19);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push  <= 1'b1;
        i_box <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic send_idle();
        push <= 1'b0;
    endtask

    function automatic logic [31:0] rand_field(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
            default: return 32'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    function automatic t_box rand_box(int mode);
        t_box b;
        b.origin_x = rand_field(mode);
        b.origin_y = rand_field(mode);
        b.origin_z = rand_field(mode);
        b.extent_x = rand_field(mode);
        b.extent_y = rand_field(mode);
        b.extent_z = rand_field(mode);
        return b;
    endfunction

    // random Q4.12 row; small coefficients keep quotients in range mostly
    function automatic logic [REG_W-1:0] rand_row();
        logic [REG_W-1:0] r;
        for (int k = 0; k < 4; k++)
            r[16*k +: 16] = $urandom_range(0, 3) == 0 ? 16'($urandom())
                          : 16'($signed($urandom_range(0, 8192)) - 4096);
        return r;
    endfunction

    initial begin
        t_box b;
        calm    = 1'b0;
        cycles  = 0;
        i_rst_n = 1'b0;
        push    = 1'b0;
        i_box   = '0;
        pop     = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset matrix, field extremes, flat box
        send_box('0);
        b = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000};
        send_box(b);
        b = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001};
        send_box(b);
        b = '{32'h0001_0000, 32'h0002_0000, 32'h0000_0000,
              32'h0001_0000, 32'h0001_0000, 32'h0000_0000};
        send_box(b);   // flat box, every corner at z=0
        send_idle();
        wait_drained();

        // extreme coefficients, w constant, edges off
        reg_write(REG_ROW_X, 64'h8000_7FFF_8000_7FFF);
        reg_write(REG_ROW_Y, 64'h7FFF_8000_7FFF_8000);
        reg_write(REG_ROW_W, 64'h0001_0000_0000_0000);
        send_box(rand_box(0));
        send_box(rand_box(2));
        send_idle();
        wait_drained();
        reg_write(REG_DRAW_EDGES, 64'h0);
        send_box(rand_box(0));
        send_box(rand_box(1));
        send_idle();
        wait_drained();
        reg_write(REG_DRAW_EDGES, 64'hFFFF_FFFF_FFFF_FFFE);
        send_box(rand_box(0));
        send_idle();
        wait_drained();
        reg_write(REG_DRAW_EDGES, 64'h1);
        reg_write(REG_ROW_W, 64'hFFFF_FFFF_FFFF_FFFF);
        send_box(rand_box(1));
        send_box(rand_box(0));
        send_idle();
        wait_drained();

        // random phases with new matrices between them
        for (int ph = 0; ph < 6; ph++) begin
            reg_write(REG_ROW_X, rand_row());
            reg_write(REG_ROW_Y, rand_row());
            reg_write(REG_ROW_W, rand_row());
            reg_write(REG_DRAW_EDGES, ph == 3 ? 64'h0 : 64'h1);
            if (ph == 5)
                calm = 1'b1;
            for (int i = 0; i < 18; i++)
                send_box(rand_box($urandom_range(0, 2)));
            send_idle();
            wait_drained();
        end

        // end of run
        wait_drained();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/bep_pkg.sv
rtl/bep_front.sv
rtl/bep_queue.sv
rtl/bep_transform.sv
rtl/bep_divider.sv
rtl/box_edge_projection_top.sv
tb/box_edge_projection_checker.sv
tb/box_edge_projection_top_test.sv
